// ===== rtl/lzte_pkg.sv =====
// Shared types for the LZ77 triple encoder.
// No dependencies; lz77_triple_encoder and lzte_cell import this package.
package lzte_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

// ===== rtl/lz77_triple_encoder.sv =====
// Top level of the LZ77 triple encoder: control, history RAM and the matcher chain.
// Depends on lzte_pkg, lzte_ram and lzte_cell.
//
// Bytes are taken one per transfer into the lookahead. When the lookahead is full, or a byte
// carries the end mark, the block searches the history by streaming it, oldest byte first,
// from the history RAM past a chain of LOOKAHEAD_BYTES cells; every history position starts a
// candidate that walks the chain. The search reads one history byte per cycle through the
// single RAM read port. It is followed by a shift that moves the matched bytes and then the
// literal into history through the RAM write port, the literal when the triple is emitted.
// The input is stalled from the start of the search until the triple is emitted.
// At the end mark the lookahead is flushed as a burst of triples and the block starts a new
// stream. No clearing pass is needed after reset.
module lz77_triple_encoder #(
    parameter int WINDOW_BYTES    = 4096,
    parameter int LOOKAHEAD_BYTES = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_end_of_stream,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [$clog2(WINDOW_BYTES+1)-1:0]  o_match_distance,
    output logic [$clog2(LOOKAHEAD_BYTES)-1:0] o_match_length,
    output logic [7:0]                         o_literal_byte,
    output logic                               o_last_token
);
    import lzte_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_BYTES);
    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam int LEN_W  = $clog2(LOOKAHEAD_BYTES);
    localparam int CNT_W  = $clog2(LOOKAHEAD_BYTES + 1);
    localparam int SCNT_W = $clog2(WINDOW_BYTES + LOOKAHEAD_BYTES + 2);

    t_state           r_state, n_state;
    t_cell_ctrl       cell_ctrl;
    logic [FILL_W-1:0] r_fill;
    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [SCNT_W-1:0] r_scnt;
    logic [ADDR_W-1:0] r_raddr;
    logic              r_rd_valid;
    logic [FILL_W-1:0] r_inj_dist;
    logic [LEN_W-1:0]  r_best_len;
    logic [FILL_W-1:0] r_best_dist;
    logic [LEN_W-1:0]  r_shift_left;
    logic              r_end;
    logic [7:0]        hist_byte;
    logic              push;
    logic              emit_fire;
    logic              search_done;
    logic              rd_issue;
    logic [FILL_W:0]   oldest;

    logic [7:0]        la        [LOOKAHEAD_BYTES+1];
    logic              tok_valid [LOOKAHEAD_BYTES+1];
    logic              tok_alive [LOOKAHEAD_BYTES+1];
    logic [LEN_W-1:0]  tok_len   [LOOKAHEAD_BYTES+1];
    logic [FILL_W-1:0] tok_dist  [LOOKAHEAD_BYTES+1];

    assign search_done = (r_scnt == SCNT_W'(r_fill) + SCNT_W'(LOOKAHEAD_BYTES + 1));
    assign rd_issue    = (r_state == ST_SEARCH) && (r_scnt < SCNT_W'(r_fill));
    assign oldest      = ({1'b0, FILL_W'(r_head)} >= {1'b0, r_fill})
                       ? ({1'b0, FILL_W'(r_head)} - {1'b0, r_fill})
                       : ({1'b0, FILL_W'(r_head)} + (FILL_W+1)'(WINDOW_BYTES) - {1'b0, r_fill});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && (i_end_of_stream || (r_count == CNT_W'(LOOKAHEAD_BYTES - 1)))) begin
                    n_state = ST_START;
                end
            end
            ST_START:  n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (search_done) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_shift_left == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    n_state = (r_end && (r_count != CNT_W'(1))) ? ST_START : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall        = (r_state != ST_IDLE);
        emit_fire      = (r_state == ST_EMIT) && (!o_valid || !i_stall);
        push           = ((r_state == ST_SHIFT) && (r_shift_left != '0)) || emit_fire;
        cell_ctrl.load  = (r_state == ST_IDLE) && i_valid;
        cell_ctrl.shift = push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_issue;
            o_valid    <= emit_fire || (o_valid && i_stall);
            if (cell_ctrl.load) begin
                r_count <= r_count + CNT_W'(1);
            end else if (push) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (emit_fire && r_end && (r_count == CNT_W'(1))) begin
                r_fill <= '0;
                r_head <= '0;
            end else if (push) begin
                r_head <= (r_head == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : r_head + ADDR_W'(1);
                if (r_fill != FILL_W'(WINDOW_BYTES)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ctrl.load) begin
            r_end <= i_end_of_stream;
        end
        if (r_state == ST_START) begin
            r_scnt      <= '0;
            r_raddr     <= ADDR_W'(oldest);
            r_inj_dist  <= r_fill;
            r_best_len  <= '0;
            r_best_dist <= '0;
        end else begin
            if (r_state == ST_SEARCH) begin
                r_scnt <= r_scnt + SCNT_W'(1);
            end
            if (rd_issue) begin
                r_raddr <= (r_raddr == ADDR_W'(WINDOW_BYTES - 1)) ? '0 : r_raddr + ADDR_W'(1);
            end
            if (r_rd_valid) begin
                r_inj_dist <= r_inj_dist - FILL_W'(1);
            end
            if (tok_valid[LOOKAHEAD_BYTES] && (tok_len[LOOKAHEAD_BYTES] > r_best_len)) begin
                r_best_len  <= tok_len[LOOKAHEAD_BYTES];
                r_best_dist <= tok_dist[LOOKAHEAD_BYTES];
            end
        end
        if (r_state == ST_SEARCH) begin
            r_shift_left <= r_best_len;
        end else if (push && (r_state == ST_SHIFT)) begin
            r_shift_left <= r_shift_left - LEN_W'(1);
        end
        if (emit_fire) begin
            o_match_distance <= r_best_dist;
            o_match_length   <= r_best_len;
            o_literal_byte   <= la[0];
            o_last_token     <= r_end && (r_count == CNT_W'(1));
        end
    end

    lzte_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_head),
        .i_wdata (la[0]),
        .i_raddr (r_raddr),
        .o_rdata (hist_byte)
    );

    assign tok_valid[0] = r_rd_valid;
    assign tok_alive[0] = 1'b1;
    assign tok_len[0]   = '0;
    assign tok_dist[0]  = r_inj_dist;
    assign la[LOOKAHEAD_BYTES] = 8'h00;

    for (genvar k = 0; k < LOOKAHEAD_BYTES; k++) begin : g_cell
        lzte_cell #(
            .IDX    (k),
            .LEN_W  (LEN_W),
            .DIST_W (FILL_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_count      (r_count),
            .i_cap        (r_count - CNT_W'(1)),
            .i_byte       (i_data_byte),
            .i_next_la    (la[k+1]),
            .o_la         (la[k]),
            .i_hist_byte  (hist_byte),
            .i_hist_valid (r_rd_valid),
            .i_tok_valid  (tok_valid[k]),
            .i_tok_alive  (tok_alive[k]),
            .i_tok_len    (tok_len[k]),
            .i_tok_dist   (tok_dist[k]),
            .o_tok_valid  (tok_valid[k+1]),
            .o_tok_alive  (tok_alive[k+1]),
            .o_tok_len    (tok_len[k+1]),
            .o_tok_dist   (tok_dist[k+1])
        );
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LOOKAHEAD_BYTES))
        else $error("Lookahead count exceeds its depth.");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_BYTES))
        else $error("History fill exceeds the window.");

    a_len_le_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |=> (FILL_W'(o_match_length) <= o_match_distance))
        else $error("Match runs past the end of the history.");

    a_no_match_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && (r_best_len == '0) |-> (r_best_dist == '0))
        else $error("Distance given without a match.");

    a_emit_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("Triple emitted from an empty lookahead.");

endmodule

// ===== rtl/lzte_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lzte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/lzte_cell.sv =====
// One matcher cell: holds one lookahead byte and one candidate token in flight.
// Depends on lzte_pkg.
module lzte_cell #(
    parameter int IDX    = 0,
    parameter int LEN_W  = 5,
    parameter int DIST_W = 13,
    parameter int CNT_W  = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lzte_pkg::t_cell_ctrl  i_ctrl,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [CNT_W-1:0]      i_cap,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_next_la,
    output logic [7:0]            o_la,
    input  logic [7:0]            i_hist_byte,
    input  logic                  i_hist_valid,
    input  logic                  i_tok_valid,
    input  logic                  i_tok_alive,
    input  logic [LEN_W-1:0]      i_tok_len,
    input  logic [DIST_W-1:0]     i_tok_dist,
    output logic                  o_tok_valid,
    output logic                  o_tok_alive,
    output logic [LEN_W-1:0]      o_tok_len,
    output logic [DIST_W-1:0]     o_tok_dist
);
    import lzte_pkg::*;

    logic [7:0] r_la;
    logic       hit;

    assign hit = i_tok_alive && i_hist_valid && (CNT_W'(IDX) < i_cap) && (i_hist_byte == r_la);
    assign o_la = r_la;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && (i_count == CNT_W'(IDX))) begin
            r_la <= i_byte;
        end else if (i_ctrl.shift) begin
            r_la <= i_next_la;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok_valid <= 1'b0;
        end else begin
            o_tok_valid <= i_tok_valid;
        end
        o_tok_alive <= hit;
        o_tok_len   <= hit ? LEN_W'(IDX + 1) : i_tok_len;
        o_tok_dist  <= i_tok_dist;
    end

endmodule
